/* rtl/ksdb_pkg.sv */
// Package for the key switch debouncer: state codes, phase codes, register map
// and the configuration bundle shared by the register file, core and top level.
// No dependencies.
`default_nettype none

package ksdb_pkg;

  // Widths fixed by the fields
  localparam int unsigned CntW   = 8;
  localparam int unsigned OpW    = 2;
  localparam int unsigned KeyW   = 2;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  // Register reset values
  localparam logic [CntW-1:0] HighCountRst   = 8'd80;
  localparam logic [CntW-1:0] LowCountRst    = 8'd105;
  localparam logic [CntW-1:0] InitTimeoutRst = 8'd120;

  // Register indexes (word address)
  localparam logic [1:0] RegHighCount   = 2'd0;
  localparam logic [1:0] RegLowCount    = 2'd1;
  localparam logic [1:0] RegInitTimeout = 2'd2;

  // Commands
  localparam logic [OpW-1:0] OpSample     = 2'd0;
  localparam logic [OpW-1:0] OpForceOpen  = 2'd1;
  localparam logic [OpW-1:0] OpForceClose = 2'd2;
  localparam logic [OpW-1:0] OpClearPhase = 2'd3;

  // Reported key state
  localparam logic [KeyW-1:0] KeyInit   = 2'd0;
  localparam logic [KeyW-1:0] KeyOpened = 2'd1;
  localparam logic [KeyW-1:0] KeyClosed = 2'd2;

  // Sub-process phases
  localparam logic [PhaseW-1:0] PhIdle = 2'd0;
  localparam logic [PhaseW-1:0] PhLow  = 2'd1;  // init: low run; level: counting
  localparam logic [PhaseW-1:0] PhHigh = 2'd2;  // init: high run; level: confirmed

  typedef enum logic [2:0] {
    TopInit   = 3'b001,
    TopOpened = 3'b010,
    TopClosed = 3'b100
  } top_state_e;

  typedef struct packed {
    logic [CntW-1:0] high_count;
    logic [CntW-1:0] low_count;
    logic [CntW-1:0] init_timeout;
  } cfg_t;

endpackage : ksdb_pkg

`default_nettype wire

/* rtl/ksdb_cfg_regs.sv */
// APB-style configuration register file for the key switch debouncer.
// Depends on ksdb_pkg.
`default_nettype none

module ksdb_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ksdb_pkg::AddrW-1:0] paddr,
  input  wire logic [ksdb_pkg::DataW-1:0] pwdata,
  output logic      [ksdb_pkg::DataW-1:0] prdata,
  output logic                            pready,
  output ksdb_pkg::cfg_t                  cfg_o
);
  import ksdb_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegHighCount:   cfg_d.high_count   = pwdata[CntW-1:0];
        RegLowCount:    cfg_d.low_count    = pwdata[CntW-1:0];
        RegInitTimeout: cfg_d.init_timeout = pwdata[CntW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_count   <= HighCountRst;
      cfg_q.low_count    <= LowCountRst;
      cfg_q.init_timeout <= InitTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      RegHighCount:   prdata = {{(DataW-CntW){1'b0}}, cfg_q.high_count};
      RegLowCount:    prdata = {{(DataW-CntW){1'b0}}, cfg_q.low_count};
      RegInitTimeout: prdata = {{(DataW-CntW){1'b0}}, cfg_q.init_timeout};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule : ksdb_cfg_regs

`default_nettype wire

/* rtl/ksdb_core.sv */
// Debounce state machine: top state, sub-process phases, init step counter
// and the shared run counter, updated once per stepped transaction.
// Depends on ksdb_pkg.
`default_nettype none

module ksdb_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic [ksdb_pkg::OpW-1:0]   op_i,
  input  wire logic                       pin_level_i,
  input  wire ksdb_pkg::cfg_t             cfg_i,
  output logic      [ksdb_pkg::KeyW-1:0]  key_state_o,
  output logic                            state_changed_o
);
  import ksdb_pkg::*;

  top_state_e        top_q, top_d;
  logic [PhaseW-1:0] init_ph_q, init_ph_d;
  logic [PhaseW-1:0] open_ph_q, open_ph_d;
  logic [PhaseW-1:0] close_ph_q, close_ph_d;
  logic [CntW-1:0]   steps_q, steps_d;
  logic [CntW-1:0]   run_q, run_d;

  logic [CntW-1:0]   run_inc;
  logic [PhaseW-1:0] decision;
  logic [PhaseW-1:0] pin_phase;
  logic              want;

  assign run_inc   = run_q + 8'd1;
  assign pin_phase = pin_level_i ? PhHigh : PhLow;

  always_comb begin
    top_d      = top_q;
    init_ph_d  = init_ph_q;
    open_ph_d  = open_ph_q;
    close_ph_d = close_ph_q;
    steps_d    = steps_q;
    run_d      = run_q;
    decision   = PhIdle;
    want       = 1'b0;

    case (op_i)
      OpForceOpen, OpForceClose: begin
        top_d      = (op_i == OpForceOpen) ? TopOpened : TopClosed;
        open_ph_d  = PhIdle;
        close_ph_d = PhIdle;
        run_d      = '0;
      end
      OpClearPhase: begin
        open_ph_d  = PhIdle;
        close_ph_d = PhIdle;
      end
      default: begin
        case (top_q)
          TopInit: begin
            steps_d = steps_q + 8'd1;
            case (init_ph_q)
              PhIdle: begin
                run_d     = 8'd1;
                init_ph_d = pin_phase;
              end
              PhLow, PhHigh: begin
                want = (init_ph_q == PhHigh);
                if (pin_level_i == want) begin
                  if (run_inc >= cfg_i.high_count) begin
                    decision  = init_ph_q;
                    init_ph_d = PhIdle;
                    run_d     = '0;
                  end else begin
                    run_d = run_inc;
                  end
                end else begin
                  init_ph_d = pin_phase;
                  run_d     = 8'd1;
                end
              end
              default: init_ph_d = PhIdle;
            endcase
            // Timeout falls back to whatever phase the step left behind
            if (decision == PhIdle && steps_d >= cfg_i.init_timeout) begin
              decision  = init_ph_d;
              init_ph_d = PhIdle;
              run_d     = '0;
              steps_d   = '0;
            end
            if (decision == PhLow) begin
              top_d      = TopOpened;
              close_ph_d = PhIdle;
            end else if (decision == PhHigh) begin
              top_d     = TopClosed;
              open_ph_d = PhIdle;
            end
          end
          TopOpened: begin
            // Wait for a confirmed high run, then switch on the next sample
            case (open_ph_q)
              PhIdle: begin
                if (pin_level_i) begin
                  run_d     = 8'd1;
                  open_ph_d = PhLow;
                end
              end
              PhLow: begin
                if (pin_level_i) begin
                  if (run_inc >= cfg_i.high_count) begin
                    run_d     = '0;
                    open_ph_d = PhHigh;
                  end else begin
                    run_d = run_inc;
                  end
                end else begin
                  open_ph_d = PhIdle;
                end
              end
              default: begin
                top_d     = TopClosed;
                open_ph_d = PhIdle;
              end
            endcase
          end
          TopClosed: begin
            // Mirror of the opened side on low samples
            case (close_ph_q)
              PhIdle: begin
                if (!pin_level_i) begin
                  run_d      = 8'd1;
                  close_ph_d = PhLow;
                end
              end
              PhLow: begin
                if (!pin_level_i) begin
                  if (run_inc >= cfg_i.low_count) begin
                    run_d      = '0;
                    close_ph_d = PhHigh;
                  end else begin
                    run_d = run_inc;
                  end
                end else begin
                  close_ph_d = PhIdle;
                end
              end
              default: begin
                top_d      = TopOpened;
                close_ph_d = PhIdle;
              end
            endcase
          end
          default: top_d = top_q;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q      <= TopInit;
      init_ph_q  <= PhIdle;
      open_ph_q  <= PhIdle;
      close_ph_q <= PhIdle;
      steps_q    <= '0;
      run_q      <= '0;
    end else if (step_i) begin
      top_q      <= top_d;
      init_ph_q  <= init_ph_d;
      open_ph_q  <= open_ph_d;
      close_ph_q <= close_ph_d;
      steps_q    <= steps_d;
      run_q      <= run_d;
    end
  end

  always_comb begin
    case (top_d)
      TopOpened: key_state_o = KeyOpened;
      TopClosed: key_state_o = KeyClosed;
      default:   key_state_o = KeyInit;
    endcase
  end

  assign state_changed_o = (top_d != top_q);

endmodule : ksdb_core

`default_nettype wire

/* rtl/key_switch_debounce_fsm_unit.sv */
// Top level of the key switch debouncer: input register, debounce core,
// result register and the configuration port.
// Depends on ksdb_pkg, ksdb_cfg_regs and ksdb_core.
`default_nettype none

// Key switch debouncer. Each input transaction carries a command (sample pin,
// force opened, force closed, clear phases) and a pin level; each one yields
// exactly one result transaction with the key state after it (0 init, 1
// opened, 2 closed) and a flag that the state changed. A transaction waits in
// the input register until the result register is free; the debounce state
// updates as it moves to the result register, where the result is held
// valid until taken. One transaction is taken every cycle; only a stalled result
// register holds the flow. Registers high_count (0x0), low_count (0x4) and
// init_timeout (0x8) are to be written over the APB-style port only while idle;
// the block itself does not enforce this.
module key_switch_debounce_fsm_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [ksdb_pkg::OpW-1:0]   op_i,
  input  wire logic                       pin_level_i,
  // result channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [ksdb_pkg::KeyW-1:0]  key_state_o,
  output logic                            state_changed_o,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ksdb_pkg::AddrW-1:0] paddr,
  input  wire logic [ksdb_pkg::DataW-1:0] pwdata,
  output logic      [ksdb_pkg::DataW-1:0] prdata,
  output logic                            pready
);
  import ksdb_pkg::*;

  cfg_t            cfg;
  logic            in_valid_q, in_valid_d;
  logic [OpW-1:0]  op_q;
  logic            pin_q;
  logic            out_valid_q, out_valid_d;
  logic [KeyW-1:0] key_state_q;
  logic            changed_q;
  logic [KeyW-1:0] key_state_nx;
  logic            changed_nx;
  logic            out_free;
  logic            step;
  logic            in_take;

  // Result slot is free when empty or being drained this cycle
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign step       = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  ksdb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ksdb_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .op_i            (op_q),
    .pin_level_i     (pin_q),
    .cfg_i           (cfg),
    .key_state_o     (key_state_nx),
    .state_changed_o (changed_nx)
  );

  // Hold the input slot full until the core steps on it
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  // Load a fresh result on a step, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q  <= op_i;
      pin_q <= pin_level_i;
    end
    if (step) begin
      key_state_q <= key_state_nx;
      changed_q   <= changed_nx;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign key_state_o     = key_state_q;
  assign state_changed_o = changed_q;

endmodule : key_switch_debounce_fsm_unit

`default_nettype wire
